// ----- design/tdpt_pkg.sv -----
// Package for the trial-division prime test unit.
// Holds the default operand width and the control/status bundles of the remainder unit.
// No dependencies.
package tdpt_pkg;

  // Default operand width
  localparam int unsigned VALUE_WIDTH_DEF = 24;

  // Sequencer to remainder unit
  typedef struct packed {
    logic start;
  } rem_ctl_t;

  // Remainder unit to sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_sts_t;

endpackage

// ----- design/tdpt_if.sv -----
// Valid/ready channel interfaces of the trial-division prime test unit.
// Input channel carries the operand, output channel the prime flag. Uses no package.
interface tdpt_in_if #(
  parameter int unsigned VALUE_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_out_if;
  logic valid;
  logic ready;
  logic prime;

  modport source (output valid, output prime, input ready);
  modport sink   (input valid, input prime, output ready);
endinterface

// ----- design/trial_division_prime_test_unit.sv -----
// Trial-division prime test unit: top level with divisor sequencer and result register.
// Depends on tdpt_pkg, tdpt_if (channel interfaces) and tdpt_rem_unit.
//
// Usage:
//   in_ch  : one beat carries an unsigned value of VALUE_WIDTH bits.
//   out_ch : one beat carries prime, 1 when the value is prime (0 and 1 are not).
//   Exactly one output beat per input beat, in order.
//   Divisors d = 2, 3, ... are tried while d*d <= value; d*d is kept by adding
//   2d+1 per step. Each trial is one bound check followed by a division in the
//   shared bit-serial remainder unit, which sets the rate.
//   in_ch.ready is high only while no item is at work; it rises with out_ch.valid.
//   A finished result waits in the output register; the next item is accepted
//   meanwhile and its result is held back until the receiver takes the first.
//   Reset (rst_n low, synchronous) drops any item at work and any held result.
module trial_division_prime_test_unit #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tdpt_in_if.sink    in_ch,
  tdpt_out_if.source out_ch
);

  localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 1;  // divisor width
  localparam int unsigned SW = VALUE_WIDTH + 2;            // divisor square width

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] v_r, v_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [SW-1:0]          sq_r, sq_nxt;
  logic                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;

  tdpt_pkg::rem_ctl_t     rem_ctl;
  tdpt_pkg::rem_sts_t     rem_sts;

  logic                   in_beat;
  logic                   below_two;
  logic                   sq_fits;
  logic                   out_free;

  assign in_beat   = in_ch.valid && in_ch.ready;
  assign below_two = (v_r[VALUE_WIDTH-1:1] == '0);
  assign sq_fits   = (sq_r <= SW'(v_r));
  assign out_free  = !out_valid_r || out_ch.ready;

  // Shared remainder unit
  tdpt_rem_unit #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIV_WIDTH   (DW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (v_r),
    .divisor  (d_r),
    .sts      (rem_sts)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    rem_ctl.start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          v_nxt     = in_ch.value;
          d_nxt     = DW'(2);
          sq_nxt    = SW'(4);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (below_two) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else if (!sq_fits) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          rem_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SW'({d_r, 1'b1});
            d_nxt     = d_r + 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FIN && out_free) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.prime = out_prime_r;

`ifndef SYNTHESIS
  // Running square tracks the divisor
  a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_DIV) |-> sq_r == SW'(d_r) * SW'(d_r))
    else $error("divisor square out of step");

  // Trial divisors start at two
  a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_DIV) |-> d_r >= DW'(2))
    else $error("trial divisor below two");

  // A division only runs while the divisor square is within the value
  a_div_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> sq_fits && !below_two)
    else $error("division beyond divisor bound");
`endif

endmodule

// ----- design/tdpt_rem_unit.sv -----
// Bit-serial restoring remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on tdpt_pkg for the control/status bundles.
module tdpt_rem_unit #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tdpt_pkg::rem_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [DIV_WIDTH-1:0]   divisor,
  output tdpt_pkg::rem_sts_t     sts
);

  localparam int unsigned CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(VALUE_WIDTH - 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [DIV_WIDTH-1:0]   rem_r, rem_nxt;
  logic [DIV_WIDTH-1:0]   dsr_r, dsr_nxt;
  logic [VALUE_WIDTH-1:0] dvd_r, dvd_nxt;

  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH:0]     diff;
  logic                   ge;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_r, dvd_r[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
  end

  assign sts.done     = done_r;
  assign sts.rem_zero = (rem_r == '0);

`ifndef SYNTHESIS
  // Sequencer never restarts a division in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("remainder unit restarted while busy");

  // Completion follows the last step of a running division
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("remainder done without a running division");

  // Final remainder is reduced below the divisor
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < dsr_r)
    else $error("remainder not reduced");
`endif

endmodule
